// ===== rtl/es2ud_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the epoch-seconds to UTC date converter.
package es2ud_pkg;

    // Calendar constants
    localparam int unsigned DAYS_TO_EPOCH    = 719162;   // days from 0001-01-01 to 1970-01-01
    localparam int unsigned DAYS_400Y        = 146097;
    localparam int unsigned DAYS_100Y        = 36524;
    localparam int unsigned DAYS_4Y          = 1461;
    localparam int unsigned DAYS_1Y          = 365;
    localparam int unsigned DAYS_PER_WEEK    = 7;
    localparam int unsigned FEB_END          = 31 + 28;  // first day of March, common year
    localparam int unsigned LAST_IN_CYCLE    = 3;        // clamp for folded century / year
    localparam int unsigned LAST_4Y_IN_100Y  = 24;
    localparam int unsigned MONTHS           = 12;

    // Year arithmetic, taken modulo 256 for the 8-bit year field
    localparam int unsigned YEARS_400        = 400;
    localparam int unsigned YEARS_100        = 100;
    localparam int unsigned YEARS_4          = 4;
    localparam int unsigned YEAR_BASE        = 1899;
    localparam int unsigned YEAR_BIAS        = 256 * ((YEAR_BASE + 255) / 256) - YEAR_BASE;

    // 86400 = 675 << 7: seconds-per-day divide is a shift plus a divide by 675
    localparam int unsigned SEC_LOW_BITS     = 7;
    localparam int unsigned SEC_MID_BITS     = 16;
    localparam int unsigned SEC_ODD_DIV      = 675;
    localparam int unsigned SEC_ODD_REM_W    = 10;
    localparam int unsigned SEC_PER_MIN      = 60;
    localparam int unsigned MIN_PER_HOUR     = 60;

    // Pipeline depth of the building blocks
    localparam int unsigned DIV_STAGES       = 4;
    localparam int unsigned MONTH_STAGES     = 3;

    // First day of each month in a leap year, day-of-year numbering
    localparam logic [8:0] MONTH_START [MONTHS] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // Time of day
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // Cycle split of the day count plus fields carried alongside it
    typedef struct packed {
        logic [7:0] q400;   // 400-year cycles, low 8 bits only
        logic [1:0] c;      // century within the 400-year cycle
        logic [4:0] q4;     // 4-year cycle within the century
        logic [1:0] y1;     // year within the 4-year cycle
        logic [8:0] rem;    // day within the year
        logic [2:0] wd;     // weekday
        t_tod       tod;
    } t_cycles;

    // Result fields except the daylight-saving flag, lowest field in the LSBs
    typedef struct packed {
        logic [8:0] day_of_year;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [3:0] month;
        logic [4:0] day_of_month;
        t_tod       tod;
    } t_date;

endpackage

// ===== rtl/es2ud_cdiv.sv =====
`timescale 1ns / 1ps
// Four-stage pipelined divider by a constant: reciprocal multiply plus one correction.
module es2ud_cdiv
    import es2ud_pkg::*;
#(
    parameter int unsigned XW = 16,
    parameter int unsigned D  = 60,
    parameter int unsigned QW = 8,
    parameter int unsigned RW = 6,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_q,
    output logic [RW-1:0] o_r,
    output logic [SW-1:0] o_side
);

    // Reciprocal floor(2^K / D) with K = XW: the estimate is low by at most one
    localparam int unsigned K  = XW;
    localparam int unsigned MW = (K + 2 > $clog2(D) + 1) ? K + 2 - $clog2(D) : 1;
    localparam int unsigned PW = XW + MW;
    localparam logic [MW-1:0] M = MW'((64'd1 << K) / D);

    logic [XW-1:0] r_x1, r_x2;
    logic [SW-1:0] r_s1, r_s2, r_s3, r_s4;
    logic [PW-1:0] r_prod;
    logic [MW-1:0] r_q3, r_q4, n_q3, n_q4;
    logic [XW-1:0] r_r3, r_r4, n_r3, n_r4;

    // Quotient estimate and partial remainder
    always_comb begin
        n_q3 = r_prod[K +: MW];
        n_r3 = r_x2 - XW'(n_q3 * D);
    end

    // One-step correction
    always_comb begin
        if (r_r3 >= D) begin
            n_q4 = r_q3 + 1'b1;
            n_r4 = r_r3 - XW'(D);
        end else begin
            n_q4 = r_q3;
            n_r4 = r_r3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= i_x;
            r_s1   <= i_side;
            r_x2   <= r_x1;
            r_prod <= r_x1 * M;
            r_s2   <= r_s1;
            r_q3   <= n_q3;
            r_r3   <= n_r3;
            r_s3   <= r_s2;
            r_q4   <= n_q4;
            r_r4   <= n_r4;
            r_s4   <= r_s3;
        end
    end

    assign o_q    = QW'(r_q4);
    assign o_r    = RW'(r_r4);
    assign o_side = r_s4;

endmodule

// ===== rtl/es2ud_month.sv =====
`timescale 1ns / 1ps
// Three-stage month / day-of-month lookup and year assembly.
module es2ud_month
    import es2ud_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cycles i_cyc,
    output t_date   o_date
);

    logic       leap;
    logic [8:0] n_t1, r_t1, r_t2;
    logic [7:0] n_yr1, r_yr1, r_yr2;
    logic [8:0] r_doy1, r_doy2;
    logic [2:0] r_wd1, r_wd2;
    t_tod       r_tod1, r_tod2;
    logic [3:0] n_m2, r_m2;
    t_date      r_date;

    // Stage 1: leap year, skip Feb 29 in common years, year modulo 256
    always_comb begin
        leap  = (i_cyc.y1 == 2'(LAST_IN_CYCLE)) &&
                ((i_cyc.q4 != 5'(LAST_4Y_IN_100Y)) || (i_cyc.c == 2'(LAST_IN_CYCLE)));
        n_t1  = i_cyc.rem + 9'(!leap && (i_cyc.rem >= 9'(FEB_END)));
        n_yr1 = i_cyc.q400 * 8'(YEARS_400) + 8'(i_cyc.c) * 8'(YEARS_100)
              + 8'(i_cyc.q4) * 8'(YEARS_4) + 8'(i_cyc.y1) + 8'(YEAR_BIAS);
    end

    // Stage 2: month = number of month starts after January at or below the day
    always_comb begin
        n_m2 = '0;
        for (int k = 1; k < MONTHS; k++) begin
            n_m2 = n_m2 + 4'(r_t1 >= MONTH_START[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= n_t1;
            r_yr1  <= n_yr1;
            r_doy1 <= i_cyc.rem;
            r_wd1  <= i_cyc.wd;
            r_tod1 <= i_cyc.tod;

            r_m2   <= n_m2;
            r_t2   <= r_t1;
            r_yr2  <= r_yr1;
            r_doy2 <= r_doy1;
            r_wd2  <= r_wd1;
            r_tod2 <= r_tod1;

            // Stage 3: day of month from the month start
            r_date.day_of_year      <= r_doy2;
            r_date.weekday          <= r_wd2;
            r_date.years_since_1900 <= r_yr2;
            r_date.month            <= r_m2;
            r_date.day_of_month     <= 5'(r_t2 - MONTH_START[r_m2] + 9'd1);
            r_date.tod              <= r_tod2;
        end
    end

    assign o_date = r_date;

endmodule

// ===== rtl/epoch_seconds_to_utc_date_unit.sv =====
`timescale 1ns / 1ps
// Top level of the epoch-seconds to broken-down UTC date converter.
//
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, day of month, month (0 = January), years since 1900,
// weekday (0 = Sunday) and day of year, plus the daylight-saving flag held in
// the configuration register (reset value -1). One timestamp is accepted every
// clock cycle unless the input stalls. Each result passes through six constant
// dividers in series (86400 split as 675 twice, then 146097 with 60 and 7
// alongside, 36524 with 60 alongside, 1461, 365) of four stages each, three
// stages of month lookup and the output register.
// A two-entry output buffer lets the input keep taking items while one result
// waits; the input stalls only once both entries are full. Only the low
// SECONDS_BITS bits of the input are used; above 32 bits years past 2155 wrap
// modulo 256 in years_since_1900.
module epoch_seconds_to_utc_date_unit
    import es2ud_pkg::*;
#(
    parameter int unsigned SECONDS_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration: dst_flag
    input  logic                                  i_cfg_wr_en,
    input  logic [1:0]                            i_cfg_wr_data,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((SECONDS_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,  // epoch_seconds
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // second, minute, hour, day_of_month, month, years_since_1900, weekday,
    // day_of_year, dst_out
    output logic [47:0]                           o_m_axis_tdata
);

    localparam int unsigned XHW   = SECONDS_BITS - SEC_LOW_BITS - SEC_MID_BITS;
    localparam int unsigned DAYW  = SECONDS_BITS - 16;
    localparam int unsigned DDW   = ((DAYW > 20) ? DAYW : 20) + 1;
    localparam int unsigned Q400W = DDW - 17;
    localparam int unsigned SODW  = SEC_ODD_REM_W + SEC_LOW_BITS;
    localparam int unsigned CYCW  = $bits(t_cycles);
    localparam int unsigned NP    = 6 * DIV_STAGES + MONTH_STAGES;

    logic [SECONDS_BITS-1:0] secs;
    logic                    pipe_en;
    logic [NP-1:0]           r_v;
    logic                    r_run;
    logic [1:0]              r_dst;

    // Phase A/B: seconds / 86400 as (seconds >> 7) / 675 in two digits
    logic [XHW-1:0]                          a_q;
    logic [SEC_ODD_REM_W-1:0]                a_r;
    logic [SEC_MID_BITS+SEC_LOW_BITS-1:0]    a_side;
    logic [SEC_MID_BITS-1:0]                 b_q;
    logic [SEC_ODD_REM_W-1:0]                b_r;
    logic [XHW+SEC_LOW_BITS-1:0]             b_side;
    logic [DAYW-1:0]                         days;
    logic [SODW-1:0]                         sod;
    logic [DDW-1:0]                          d, d1;

    // Phase C/D outputs
    logic [Q400W-1:0] c_q400;
    logic [17:0]      c_r400;
    logic [2:0]       c_wd;
    logic [10:0]      c_mins;
    logic [5:0]       c_sec;
    logic [2:0]       d_q;
    logic [15:0]      d_r;
    logic [10:0]      d_side;
    logic [4:0]       hr_q;
    logic [5:0]       hr_r;
    logic [5:0]       hr_side;

    // Phase E/F
    t_cycles     e_in, f_in, g_in;
    logic [4:0]  e_q;
    logic [10:0] e_r;
    logic [CYCW-1:0] e_side, f_side;
    logic [2:0]  f_q;
    logic [8:0]  f_r;

    t_date m_date;

    // Output buffer: result register plus skid entry
    t_date r_od, r_sd;
    logic  r_ov, r_sv;
    logic  push, pop;

    assign secs    = i_s_axis_tdata[SECONDS_BITS-1:0];
    assign pipe_en = !r_sv;

    es2ud_cdiv #(
        .XW(XHW), .D(SEC_ODD_DIV), .QW(XHW), .RW(SEC_ODD_REM_W),
        .SW(SEC_MID_BITS + SEC_LOW_BITS)
    ) u_div_sec_hi (
        .i_clk(i_clk), .i_en(pipe_en),
        .i_x(secs[SECONDS_BITS-1 -: XHW]),
        .i_side(secs[SEC_MID_BITS+SEC_LOW_BITS-1:0]),
        .o_q(a_q), .o_r(a_r), .o_side(a_side)
    );

    es2ud_cdiv #(
        .XW(SEC_ODD_REM_W + SEC_MID_BITS), .D(SEC_ODD_DIV), .QW(SEC_MID_BITS),
        .RW(SEC_ODD_REM_W), .SW(XHW + SEC_LOW_BITS)
    ) u_div_sec_lo (
        .i_clk(i_clk), .i_en(pipe_en),
        .i_x({a_r, a_side[SEC_MID_BITS+SEC_LOW_BITS-1:SEC_LOW_BITS]}),
        .i_side({a_q, a_side[SEC_LOW_BITS-1:0]}),
        .o_q(b_q), .o_r(b_r), .o_side(b_side)
    );

    // Day count rebased to 0001-01-01 and second of day
    always_comb begin
        days = DAYW'({b_side[XHW+SEC_LOW_BITS-1:SEC_LOW_BITS], b_q});
        sod  = {b_r, b_side[SEC_LOW_BITS-1:0]};
        d    = DDW'(days) + DDW'(DAYS_TO_EPOCH);
        d1   = DDW'(days) + DDW'(DAYS_TO_EPOCH + 1);
    end

    es2ud_cdiv #(.XW(DDW), .D(DAYS_400Y), .QW(Q400W), .RW(18), .SW(1)) u_div_400y (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(d), .i_side(1'b0),
        .o_q(c_q400), .o_r(c_r400), .o_side()
    );

    es2ud_cdiv #(.XW(DDW), .D(DAYS_PER_WEEK), .QW(1), .RW(3), .SW(1)) u_div_week (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(d1), .i_side(1'b0),
        .o_q(), .o_r(c_wd), .o_side()
    );

    es2ud_cdiv #(.XW(SODW), .D(SEC_PER_MIN), .QW(11), .RW(6), .SW(1)) u_div_min (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(sod), .i_side(1'b0),
        .o_q(c_mins), .o_r(c_sec), .o_side()
    );

    es2ud_cdiv #(.XW(18), .D(DAYS_100Y), .QW(3), .RW(16), .SW(11)) u_div_100y (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(c_r400),
        .i_side({8'(c_q400), c_wd}),
        .o_q(d_q), .o_r(d_r), .o_side(d_side)
    );

    es2ud_cdiv #(.XW(11), .D(MIN_PER_HOUR), .QW(5), .RW(6), .SW(6)) u_div_hour (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(c_mins), .i_side(c_sec),
        .o_q(hr_q), .o_r(hr_r), .o_side(hr_side)
    );

    // Fold the last day of a 400-year cycle into the fourth century
    always_comb begin
        e_in            = '0;
        e_in.q400       = d_side[10:3];
        e_in.wd         = d_side[2:0];
        e_in.c          = d_q[2] ? 2'(LAST_IN_CYCLE) : d_q[1:0];
        e_in.tod.hour   = hr_q;
        e_in.tod.minute = hr_r;
        e_in.tod.second = hr_side;
    end

    es2ud_cdiv #(.XW(16), .D(DAYS_4Y), .QW(5), .RW(11), .SW(CYCW)) u_div_4y (
        .i_clk(i_clk), .i_en(pipe_en),
        .i_x(d_q[2] ? 16'(DAYS_100Y) : d_r), .i_side(e_in),
        .o_q(e_q), .o_r(e_r), .o_side(e_side)
    );

    always_comb begin
        f_in    = e_side;
        f_in.q4 = e_q;
    end

    es2ud_cdiv #(.XW(11), .D(DAYS_1Y), .QW(3), .RW(9), .SW(CYCW)) u_div_1y (
        .i_clk(i_clk), .i_en(pipe_en), .i_x(e_r), .i_side(f_in),
        .o_q(f_q), .o_r(f_r), .o_side(f_side)
    );

    // Fold the last day of a 4-year cycle into the fourth year
    always_comb begin
        g_in     = f_side;
        g_in.y1  = f_q[2] ? 2'(LAST_IN_CYCLE) : f_q[1:0];
        g_in.rem = f_q[2] ? 9'(DAYS_1Y) : f_r;
    end

    es2ud_month u_month (
        .i_clk(i_clk), .i_en(pipe_en), .i_cyc(g_in), .o_date(m_date)
    );

    // Valid bits travel with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (pipe_en) begin
                r_v <= {r_v[NP-2:0], i_s_axis_tvalid && o_s_axis_tready};
            end
        end
    end

    assign o_s_axis_tready = r_run && pipe_en;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= 2'b11;
        end else if (i_cfg_wr_en) begin
            r_dst <= i_cfg_wr_data;
        end
    end

    // Output buffer
    assign push = pipe_en && r_v[NP-1];
    assign pop  = r_ov && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= push;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || pop) begin
            r_od <= r_sv ? r_sd : m_date;
            if (push) begin
                r_sd <= m_date;
            end
        end else if (push) begin
            r_sd <= m_date;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_dst, r_od};

endmodule

// ===== rtl/es2ud_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the UTC date converter, bound to the top level.
module es2ud_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Every field but the year and the dst flag within its calendar range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[5:0] < 6'd60) && (o_m_axis_tdata[11:6] < 6'd60)
            && (o_m_axis_tdata[16:12] < 5'd24) && (o_m_axis_tdata[21:17] != 5'd0)
            && (o_m_axis_tdata[25:22] < 4'd12) && (o_m_axis_tdata[36:34] < 3'd7)
            && (o_m_axis_tdata[45:37] < 9'd366))
        else $error("result field out of range");

    // In January the day of year follows the day of month
    a_january: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[25:22] == 4'd0) |->
            (o_m_axis_tdata[45:37] == 9'(o_m_axis_tdata[21:17]) - 9'd1))
        else $error("January day of year mismatch");

endmodule

bind epoch_seconds_to_utc_date_unit es2ud_checker u_es2ud_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);

// ===== sim/utc_date_checker.sv =====
`timescale 1ns / 1ps
// Checker for the epoch-seconds to UTC date converter: predicts each date and compares it.
module utc_date_checker
    import es2ud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_ts_valid,
    input  logic        i_ts_ready,
    input  logic [31:0] i_ts_data,     // epoch_seconds
    input  logic        i_date_valid,
    input  logic        i_date_ready,
    input  logic [47:0] i_date_data,   // second .. day_of_year, dst_out
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // keep the log readable when something is badly broken
    localparam int MAX_REPORTS = 30;

    // month lengths with a 29-day February; common years skip a day later on
    localparam int unsigned MONTH_DAYS [11] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30};

    typedef struct packed {
        logic [1:0] dst;
        t_date      date;
    } t_utc_result;

    t_utc_result expected_dates [$];
    logic [1:0]  dst_setting;

    // Broken-down UTC date of one timestamp
    function automatic t_utc_result predict_utc_date(input logic [31:0] secs,
                                                     input logic [1:0] flag);
        longint unsigned days, sod, day_num, q400, rem, cent, quad, yr, year_num, t;
        bit              leap;
        int              m;
        t_utc_result     res;
        days    = longint'(secs) / 86400;
        sod     = longint'(secs) % 86400;
        day_num = days + DAYS_TO_EPOCH;

        res.date.tod.second = 6'(sod % 60);
        res.date.tod.minute = 6'((sod / 60) % 60);
        res.date.tod.hour   = 5'(sod / 3600);
        // day 0 of the count is a Monday
        res.date.weekday    = 3'((day_num + 1) % DAYS_PER_WEEK);

        // split into 400/100/4/1-year cycles, folding the last day of a long cycle
        q400 = day_num / DAYS_400Y;
        rem  = day_num % DAYS_400Y;
        cent = rem / DAYS_100Y;
        if (cent > 3) cent = 3;
        rem  = rem - cent * DAYS_100Y;
        quad = rem / DAYS_4Y;
        rem  = rem - quad * DAYS_4Y;
        yr   = rem / DAYS_1Y;
        if (yr > 3) yr = 3;
        rem  = rem - yr * DAYS_1Y;

        leap     = (yr == 3) && (quad != 24 || cent == 3);
        year_num = q400 * 400 + cent * 100 + quad * 4 + yr;

        res.date.day_of_year = 9'(rem);

        // month walk; common years step over the missing February 29
        t = rem;
        if (!leap && t >= 59) t = t + 1;
        m = 0;
        while (m < 11 && t >= MONTH_DAYS[m]) begin
            t = t - MONTH_DAYS[m];
            m++;
        end
        res.date.day_of_month     = 5'(t + 1);
        res.date.month            = 4'(m);
        res.date.years_since_1900 = 8'(year_num - 1899);
        res.dst                   = flag;
        return res;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            if (o_fail_count < MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

    // Track config writes, queue predictions, check each result transfer
    always @(posedge i_clk) begin
        t_utc_result exp_date;
        t_utc_result act_date;
        if (!i_rst_n) begin
            dst_setting <= 2'b11;
            expected_dates.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) dst_setting <= i_cfg_wr_data;

            if (i_date_valid && i_date_ready) begin
                act_date = i_date_data;
                if (expected_dates.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $error("result transfer with no timestamp outstanding");
                    o_fail_count++;
                end else begin
                    exp_date = expected_dates.pop_front();
                    compare_field("second", int'(exp_date.date.tod.second),
                                  int'(act_date.date.tod.second));
                    compare_field("minute", int'(exp_date.date.tod.minute),
                                  int'(act_date.date.tod.minute));
                    compare_field("hour", int'(exp_date.date.tod.hour),
                                  int'(act_date.date.tod.hour));
                    compare_field("day_of_month", int'(exp_date.date.day_of_month),
                                  int'(act_date.date.day_of_month));
                    compare_field("month", int'(exp_date.date.month),
                                  int'(act_date.date.month));
                    compare_field("years_since_1900", int'(exp_date.date.years_since_1900),
                                  int'(act_date.date.years_since_1900));
                    compare_field("weekday", int'(exp_date.date.weekday),
                                  int'(act_date.date.weekday));
                    compare_field("day_of_year", int'(exp_date.date.day_of_year),
                                  int'(act_date.date.day_of_year));
                    compare_field("dst_out", int'($signed(exp_date.dst)),
                                  int'($signed(act_date.dst)));
                    o_checked++;
                end
            end

            if (i_ts_valid && i_ts_ready)
                expected_dates.push_back(predict_utc_date(i_ts_data, dst_setting));

            o_pending <= expected_dates.size();
        end
    end

endmodule

// ===== sim/epoch_seconds_to_utc_date_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the epoch-seconds to UTC date converter: stimulus and verdict.
module epoch_seconds_to_utc_date_unit_test;

    import es2ud_pkg::*;

    localparam int PHASE_ITEMS   = 306;
    localparam int NUM_PHASES    = 5;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_DIRECTED  = 22;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // epoch_seconds
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // second, minute, hour, day_of_month, month, years_since_1900, weekday,
    // day_of_year, dst_out
    logic [47:0] o_m_axis_tdata;

    int fail_count;
    int pending_dates;
    int checked_dates;
    int sent_stamps;
    int flag_settings;
    bit hold_request;

    // dates of interest: epoch limits, day edges, leap and century years
    localparam logic [31:0] DIRECTED_STAMPS [NUM_DIRECTED] = '{
        32'd0,          32'hFFFF_FFFF,  32'd86399,      32'd86400,
        32'd5097599,    32'd5097600,    32'd68169600,   32'd94694399,
        32'd946684799,  32'd946684800,  32'd951782400,  32'd951868800,
        32'd978307199,  32'd2147483647, 32'd2147483648, 32'd4107456000,
        32'd4107542400, 32'd4133980799, 32'd4133980800, 32'd4233686400,
        32'hAAAA_AAAA,  32'h5555_5555
    };

    // dst values written per phase: all four 2-bit patterns in turn, then random
    localparam logic [1:0] PHASE_FLAGS [NUM_PHASES - 1] = '{2'b00, 2'b01, 2'b10, 2'b11};

    epoch_seconds_to_utc_date_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    utc_date_checker date_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ts_valid    (i_s_axis_tvalid),
        .i_ts_ready    (o_s_axis_tready),
        .i_ts_data     (i_s_axis_tdata),
        .i_date_valid  (o_m_axis_tvalid),
        .i_date_ready  (i_m_axis_tready),
        .i_date_data   (o_m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_dates),
        .o_checked     (checked_dates)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random timestamp, biased toward year, month and day edges
    function automatic logic [31:0] pick_timestamp();
        int              r, yr, day_off;
        longint unsigned year_days, tod, stamp;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom;
        if (r < 50) return 32'hFFFF_FFFF - $urandom_range(0, 200000000);
        if (r < 60) return $urandom_range(0, 100000000);

        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: yr = 1972;
                1: yr = 2000;
                2: yr = 2100;
                default: yr = 2104;
            endcase
        end else begin
            yr = $urandom_range(1970, 2106);
        end
        // days from the epoch to January 1 of that year
        year_days = 64'(365 * (yr - 1970)
                  + ((yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400) - 477);
        case ($urandom_range(0, 7))
            0: day_off = 0;
            1: day_off = 1;
            2: day_off = 58;
            3: day_off = 59;
            4: day_off = 60;
            5: day_off = 364;
            6: day_off = 365;
            default: day_off = $urandom_range(0, 365);
        endcase
        case ($urandom_range(0, 2))
            0: tod = 0;
            1: tod = 86399;
            default: tod = 64'($urandom_range(0, 86399));
        endcase
        stamp = (year_days + 64'(day_off)) * 86400 + tod;
        if (stamp > 64'hFFFF_FFFF) return $urandom;
        return stamp[31:0];
    endfunction

    // One timestamp transfer, after an optional idle gap
    task automatic send_timestamp(input logic [31:0] secs, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = $urandom;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = secs;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_stamps++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_dates != 0) @(negedge i_clk);
    endtask

    // Register write, only with nothing in flight
    task automatic write_dst_flag(input logic [1:0] flag);
        drain_results();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = flag;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 2'($urandom);
        flag_settings++;
    endtask

    // Result side backpressure
    initial begin
        int mode, left;
        i_m_axis_tready = 1'b0;
        left = 0;
        mode = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long stall so the pipeline fills and input backs up
                i_m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0: i_m_axis_tready = 1'b1;
                1: i_m_axis_tready = ($urandom_range(0, 3) != 0);
                2: i_m_axis_tready = ($urandom_range(0, 3) == 0);
                default: begin
                    if ($urandom_range(0, 29) == 0) begin
                        i_m_axis_tready = 1'b0;
                        repeat ($urandom_range(10, 60)) @(negedge i_clk);
                    end
                    i_m_axis_tready = 1'b1;
                end
            endcase
        end
    end

    // Watchdog: cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_dates);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        bit burst;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 2'b00;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        hold_request    = 1'b0;
        sent_stamps     = 0;
        flag_settings   = 1;
        burst           = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed dates under the reset flag value
        foreach (DIRECTED_STAMPS[k])
            send_timestamp(DIRECTED_STAMPS[k], pick_gap());

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_dst_flag(ph < NUM_PHASES - 1 ? PHASE_FLAGS[ph] : 2'($urandom));
            if (ph == 1) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) burst = ($urandom_range(0, 5) == 0);
                send_timestamp(pick_timestamp(), burst ? 0 : pick_gap());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Converted %0d timestamps under %0d dst settings; %0d dates compared.",
                 sent_stamps, flag_settings, checked_dates);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d field mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
